// ----- rtl/core/sss_pkg.sv -----
// ----------------------------------------------------------------------------
// sss_pkg: shared types and constants for the servo sweep stepper
// Opcodes, register map, speed thresholds, divider sizing, the command bundle
// from controller to datapath and the configuration register bundle.
// ----------------------------------------------------------------------------
package sss_pkg;

  // Item opcodes.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;
  localparam logic [1:0] OP_SET   = 2'd3;

  // Register indexes (byte address is four times the index).
  localparam logic [1:0] REG_MIN_ANGLE    = 2'd0;
  localparam logic [1:0] REG_MAX_ANGLE    = 2'd1;
  localparam logic [1:0] REG_CENTER_ANGLE = 2'd2;
  localparam logic [1:0] REG_MIN_INTERVAL = 2'd3;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int ANG_W  = 8;
  localparam int SPD_W  = 10;
  localparam int STEP_W = 3;

  // Register reset values.
  localparam logic [ANG_W-1:0] MIN_ANGLE_RST    = 8'd0;
  localparam logic [ANG_W-1:0] MAX_ANGLE_RST    = 8'd180;
  localparam logic [ANG_W-1:0] CENTER_ANGLE_RST = 8'd90;
  localparam logic [ANG_W-1:0] MIN_INTERVAL_RST = 8'd5;

  // Sweep state reset values.
  localparam logic [STEP_W-1:0] STEP_RST     = 3'd1;
  localparam logic [ANG_W-1:0]  INTERVAL_RST = 8'd16;

  // Speed clamp and step thresholds, deg/s.
  localparam logic [SPD_W-1:0] SPD_LO  = 10'd10;
  localparam logic [SPD_W-1:0] SPD_HI  = 10'd350;
  localparam logic [SPD_W-1:0] SPD_TH1 = 10'd70;
  localparam logic [SPD_W-1:0] SPD_TH2 = 10'd150;
  localparam logic [SPD_W-1:0] SPD_TH3 = 10'd250;

  // Serial divider: 1000*step (at most 4000) over the clamped speed.
  localparam int DVD_W     = 12;
  localparam int DVS_W     = 9;
  localparam int DIV_STEPS = DVD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture the accepted item and seed the divider
    logic div_step;  // one restoring-division step
    logic commit;    // update sweep state and load the result register
  } cmd_t;

  // Configuration register contents.
  typedef struct packed {
    logic [ANG_W-1:0] low_lim;
    logic [ANG_W-1:0] high_lim;
    logic [ANG_W-1:0] home_pos;
    logic [ANG_W-1:0] min_interval;
  } cfg_t;

  // Clamp the requested speed into the supported range.
  function automatic logic [DVS_W-1:0] clamp_speed(input logic [SPD_W-1:0] v);
    logic [SPD_W-1:0] c;
    if (v < SPD_LO) begin
      c = SPD_LO;
    end else if (v > SPD_HI) begin
      c = SPD_HI;
    end else begin
      c = v;
    end
    return c[DVS_W-1:0];
  endfunction

  // Degrees per step chosen from the clamped speed.
  function automatic logic [STEP_W-1:0] speed_step(input logic [DVS_W-1:0] s);
    logic [STEP_W-1:0] st;
    if ({1'b0, s} <= SPD_TH1) begin
      st = 3'd1;
    end else if ({1'b0, s} <= SPD_TH2) begin
      st = 3'd2;
    end else if ({1'b0, s} <= SPD_TH3) begin
      st = 3'd3;
    end else begin
      st = 3'd4;
    end
    return st;
  endfunction

  // Milliseconds numerator: 1000 times the step.
  function automatic logic [DVD_W-1:0] step_dividend(input logic [STEP_W-1:0] st);
    logic [DVD_W-1:0] d;
    case (st)
      3'd1:    d = 12'd1000;
      3'd2:    d = 12'd2000;
      3'd3:    d = 12'd3000;
      default: d = 12'd4000;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/core/sss_regs.sv -----
// ----------------------------------------------------------------------------
// sss_regs: configuration register file
// APB-style slave holding the sweep limits, center angle and minimum
// step interval. Writes complete in the access phase; reads are direct.
// ----------------------------------------------------------------------------
module sss_regs
  import sss_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = paddr[3:2];

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_lim      <= MIN_ANGLE_RST;
      cfg.high_lim     <= MAX_ANGLE_RST;
      cfg.home_pos     <= CENTER_ANGLE_RST;
      cfg.min_interval <= MIN_INTERVAL_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_MIN_ANGLE:    cfg.low_lim      <= pwdata[ANG_W-1:0];
        REG_MAX_ANGLE:    cfg.high_lim     <= pwdata[ANG_W-1:0];
        REG_CENTER_ANGLE: cfg.home_pos     <= pwdata[ANG_W-1:0];
        REG_MIN_INTERVAL: cfg.min_interval <= pwdata[ANG_W-1:0];
        default:          cfg.low_lim      <= cfg.low_lim;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    unique case (idx)
      REG_MIN_ANGLE:    prdata = {{(DATA_W-ANG_W){1'b0}}, cfg.low_lim};
      REG_MAX_ANGLE:    prdata = {{(DATA_W-ANG_W){1'b0}}, cfg.high_lim};
      REG_CENTER_ANGLE: prdata = {{(DATA_W-ANG_W){1'b0}}, cfg.home_pos};
      REG_MIN_INTERVAL: prdata = {{(DATA_W-ANG_W){1'b0}}, cfg.min_interval};
      default:          prdata = '0;
    endcase
  end

endmodule

// ----- rtl/core/sss_ctrl.sv -----
// ----------------------------------------------------------------------------
// sss_ctrl: item sequencing state machine
// Accepts one item at a time, runs the serial divider for start items,
// and commits the result once the output register is free.
// ----------------------------------------------------------------------------
module sss_ctrl
  import sss_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] opcode,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output cmd_t       cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic             accept;
  logic             slot_free;
  logic             last_step;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid & in_ready;
  assign slot_free = ~out_valid | out_ready;
  assign last_step = (cnt == CNT_W'(DIV_STEPS - 1));

  // Commands to the datapath.
  always_comb begin
    cmd.load     = accept;
    cmd.div_step = (state == ST_DIV);
    cmd.commit   = (state == ST_DONE) & slot_free;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (opcode == OP_START) ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        if (last_step) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State, divider step counter and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DIV) begin
        cnt <= last_step ? '0 : cnt + 1'b1;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/sss_dp.sv -----
// ----------------------------------------------------------------------------
// sss_dp: sweep datapath
// Holds the sweep state, a restoring serial divider for the step interval,
// the angle update logic and the result register.
// ----------------------------------------------------------------------------
module sss_dp
  import sss_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  input  cfg_t             cfg,
  input  logic [1:0]       opcode,
  input  logic [SPD_W-1:0] speed,
  input  logic [ANG_W-1:0] target_angle,
  output logic [ANG_W-1:0] angle,
  output logic             sweeping,
  output logic             moved
);

  // Captured item.
  logic [1:0]        op_q;
  logic [ANG_W-1:0]  tgt_q;
  logic [DVS_W-1:0]  spd_q;
  logic [STEP_W-1:0] new_step_q;

  // Divider: remainder and dividend/quotient shift register.
  logic [DVS_W-1:0] rem;
  logic [DVD_W-1:0] dq;
  logic [DVS_W:0]   trial;
  logic             fits;
  logic [DVS_W-1:0] spd_clamped;

  // Sweep state.
  logic [ANG_W-1:0]  cur_angle;
  logic              going_up;
  logic [STEP_W-1:0] step_size;
  logic [ANG_W-1:0]  interval_ms;
  logic [ANG_W-1:0]  elapsed_ms;
  logic              active;

  logic [ANG_W-1:0]  cur_angle_next;
  logic              going_up_next;
  logic [STEP_W-1:0] step_size_next;
  logic [ANG_W-1:0]  interval_ms_next;
  logic [ANG_W-1:0]  elapsed_ms_next;
  logic              active_next;

  logic [ANG_W-1:0] el_inc;
  logic [ANG_W+1:0] up_pos;
  logic [ANG_W+1:0] dn_pos;
  logic [ANG_W+1:0] mv_pos;
  logic [ANG_W-1:0] new_interval;
  logic [ANG_W-1:0] set_pos;

  assign spd_clamped = clamp_speed(speed);

  // Item capture and divider iterations.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q       <= opcode;
      tgt_q      <= target_angle;
      spd_q      <= spd_clamped;
      new_step_q <= speed_step(spd_clamped);
      rem        <= '0;
      dq         <= step_dividend(speed_step(spd_clamped));
    end else if (cmd.div_step) begin
      rem <= fits ? DVS_W'(trial - {1'b0, spd_q}) : trial[DVS_W-1:0];
      dq  <= {dq[DVD_W-2:0], fits};
    end
  end

  assign trial = {rem, dq[DVD_W-1]};
  assign fits  = (trial >= {1'b0, spd_q});

  // Interval from the quotient, raised to the configured minimum.
  assign new_interval = (dq < {{(DVD_W-ANG_W){1'b0}}, cfg.min_interval}) ?
                        cfg.min_interval : dq[ANG_W-1:0];

  // Elapsed count saturates at its top value.
  assign el_inc = (elapsed_ms == '1) ? elapsed_ms : elapsed_ms + 1'b1;

  // Candidate angle as a signed value two bits wider than the angle.
  assign up_pos = {2'b00, cur_angle} + {{(ANG_W+2-STEP_W){1'b0}}, step_size};
  assign dn_pos = {2'b00, cur_angle} - {{(ANG_W+2-STEP_W){1'b0}}, step_size};
  assign mv_pos = going_up ? up_pos : dn_pos;

  // Set-angle clamp: lower limit tested first.
  assign set_pos = (tgt_q < cfg.low_lim) ? cfg.low_lim :
                   ((tgt_q > cfg.high_lim) ? cfg.high_lim : tgt_q);

  // Next sweep state per opcode.
  always_comb begin
    cur_angle_next   = cur_angle;
    going_up_next    = going_up;
    step_size_next   = step_size;
    interval_ms_next = interval_ms;
    elapsed_ms_next  = elapsed_ms;
    active_next      = active;
    unique case (op_q)
      OP_TICK: begin
        if (active) begin
          if (el_inc >= interval_ms) begin
            elapsed_ms_next = '0;
            if ($signed(mv_pos) >= $signed({2'b00, cfg.high_lim})) begin
              cur_angle_next = cfg.high_lim;
              going_up_next  = 1'b0;
            end else if ($signed(mv_pos) <= $signed({2'b00, cfg.low_lim})) begin
              cur_angle_next = cfg.low_lim;
              going_up_next  = 1'b1;
            end else begin
              cur_angle_next = mv_pos[ANG_W-1:0];
            end
          end else begin
            elapsed_ms_next = el_inc;
          end
        end
      end
      OP_START: begin
        step_size_next   = new_step_q;
        interval_ms_next = new_interval;
        elapsed_ms_next  = '0;
        going_up_next    = 1'b1;
        active_next      = 1'b1;
      end
      OP_STOP: begin
        active_next = 1'b0;
      end
      OP_SET: begin
        active_next    = 1'b0;
        cur_angle_next = set_pos;
      end
      default: active_next = active;
    endcase
  end

  // Sweep state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_angle   <= CENTER_ANGLE_RST;
      going_up    <= 1'b1;
      step_size   <= STEP_RST;
      interval_ms <= INTERVAL_RST;
      elapsed_ms  <= '0;
      active      <= 1'b0;
    end else if (cmd.commit) begin
      cur_angle   <= cur_angle_next;
      going_up    <= going_up_next;
      step_size   <= step_size_next;
      interval_ms <= interval_ms_next;
      elapsed_ms  <= elapsed_ms_next;
      active      <= active_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      angle    <= cur_angle_next;
      sweeping <= active_next;
      moved    <= (cur_angle_next != cur_angle);
    end
  end

endmodule

// ----- rtl/core/servo_sweep_stepper.sv -----
// Tick, stop and set-angle items go straight to the commit, and start items first run
// the 12-step restoring divider for the interval. Only one item is in work at a time:
// the next item is accepted once the previous result has been committed.
// The result register holds while out_ready is low and stalls the next commit.
// Synchronous reset restores the register defaults, the angle to 90 degrees and
// the sweep to stopped.
// ----------------------------------------------------------------------------
// servo_sweep_stepper: back-and-forth servo sweep generator
// Top level joining the configuration registers, the sequencing state
// machine and the sweep datapath.
// ----------------------------------------------------------------------------
module servo_sweep_stepper
  import sss_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        opcode,
  input  logic [SPD_W-1:0]  speed,
  input  logic [ANG_W-1:0]  target_angle,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ANG_W-1:0]  angle,
  output logic              sweeping,
  output logic              moved,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;
  cmd_t cmd;

  // Configuration registers.
  sss_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Item sequencing.
  sss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .opcode    (opcode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Sweep datapath.
  sss_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg          (cfg),
    .opcode       (opcode),
    .speed        (speed),
    .target_angle (target_angle),
    .angle        (angle),
    .sweeping     (sweeping),
    .moved        (moved)
  );

endmodule

// ----- rtl/core/sss_checker.sv -----
// ----------------------------------------------------------------------------
// sss_checker: port-level checks for the servo sweep stepper
// Watches the item channels and the configuration port of the top level.
// ----------------------------------------------------------------------------
module sss_checker
  import sss_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ANG_W-1:0]  angle,
  input logic              sweeping,
  input logic              moved,
  input logic              pready
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(angle) && $stable(sweeping)
      && $stable(moved))
    else $error("stalled result changed");

  // Only one item is in work: an accepted item closes the input.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in work");

  // A new result only appears while the input side is busy with its item.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared with no item in work");

  // The configuration port never waits.
  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

endmodule

bind servo_sweep_stepper sss_checker u_sss_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .angle     (angle),
  .sweeping  (sweeping),
  .moved     (moved),
  .pready    (pready)
);
